// ===== rtl/cdts_pkg.sv =====
// Shared types, codes and saturation helper for the countdown timer / stopwatch.
`timescale 1ns / 1ps

package cdts_pkg;

    localparam int HOURS_W = 7;
    localparam int MINS_W  = 6;
    localparam int SECS_W  = 6;

    localparam logic [HOURS_W-1:0] MAX_HR = 7'd99;
    localparam logic [MINS_W-1:0]  MAX_SM = 6'd59;
    localparam logic [HOURS_W-1:0] MAX_SM_WIDE = 7'd59;
    localparam logic [HOURS_W-1:0] BIG_STEP   = 7'd10;
    localparam logic [HOURS_W-1:0] SMALL_STEP = 7'd1;

    // Event kinds carried on tuser
    typedef enum logic [2:0] {
        EV_TICK   = 3'd0,
        EV_MODE   = 3'd1,
        EV_START  = 3'd2,
        EV_RESET  = 3'd3,
        EV_ADJUST = 3'd4
    } ev_t;

    // Unit selector for adjust events
    typedef enum logic [1:0] {
        UNIT_SECS  = 2'd0,
        UNIT_MINS  = 2'd1,
        UNIT_HOURS = 2'd2
    } unit_t;

    // Operating mode
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_COUNTDOWN = 2'd1,
        MODE_COUNT_UP  = 2'd2
    } mode_t;

    // One input beat
    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] unit;
        logic       direction;
        logic       big_step;
    } item_t;

    // One result beat, hours in the lowest bits when packed
    typedef struct packed {
        logic              expired;
        logic              running;
        logic [1:0]        run_mode;
        logic [SECS_W-1:0] seconds;
        logic [MINS_W-1:0] minutes;
        logic [HOURS_W-1:0] hours;
    } res_t;

    // Step a unit by one or ten, clamped to 0 and to top
    function automatic logic [HOURS_W-1:0] sat_adj(
        input logic [HOURS_W-1:0] v,
        input logic               up,
        input logic               big,
        input logic [HOURS_W-1:0] top
    );
        logic [HOURS_W-1:0] step;
        logic [HOURS_W:0]   sum;
        logic [HOURS_W-1:0] res;
        step = big ? BIG_STEP : SMALL_STEP;
        sum  = {1'b0, v} + {1'b0, step};
        if (up) begin
            res = (sum > {1'b0, top}) ? top : sum[HOURS_W-1:0];
        end else begin
            res = (v < step) ? '0 : v - step;
        end
        return res;
    endfunction

endpackage

// ===== rtl/cdts_in_stage.sv =====
// Input register: holds one accepted beat until the result side takes it.
`timescale 1ns / 1ps

module cdts_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  cdts_pkg::item_t s_item,
    input  logic            pop,
    output logic            item_valid,
    output cdts_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    cdts_pkg::item_t item_reg;

    // Take a new beat whenever the slot is empty or drains this cycle
    assign s_tready = !valid_reg || pop;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/cdts_engine.sv =====
// Timer state and the per-event next-state logic.
`timescale 1ns / 1ps

module cdts_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            upd,
    input  cdts_pkg::item_t item,
    output cdts_pkg::res_t  res
);

    cdts_pkg::mode_t             mode_reg, mode_next;
    logic                        run_reg, run_next;
    logic [cdts_pkg::HOURS_W-1:0] hours_reg, hours_next;
    logic [cdts_pkg::MINS_W-1:0]  mins_reg, mins_next;
    logic [cdts_pkg::SECS_W-1:0]  secs_reg, secs_next;
    logic [cdts_pkg::HOURS_W-1:0] secs_adj;
    logic [cdts_pkg::HOURS_W-1:0] mins_adj;
    logic                        expired;
    logic                        at_zero;
    logic                        at_max;

    assign at_zero = (hours_reg == '0) && (mins_reg == '0) && (secs_reg == '0);
    assign at_max  = (hours_reg == cdts_pkg::MAX_HR) && (mins_reg == cdts_pkg::MAX_SM)
                     && (secs_reg == cdts_pkg::MAX_SM);

    // Saturated adjust of seconds and minutes, widened to the helper's width
    assign secs_adj = cdts_pkg::sat_adj({1'b0, secs_reg}, item.direction,
                                        item.big_step, cdts_pkg::MAX_SM_WIDE);
    assign mins_adj = cdts_pkg::sat_adj({1'b0, mins_reg}, item.direction,
                                        item.big_step, cdts_pkg::MAX_SM_WIDE);

    // Work out the state after this event
    always_comb begin
        mode_next  = mode_reg;
        run_next   = run_reg;
        hours_next = hours_reg;
        mins_next  = mins_reg;
        secs_next  = secs_reg;
        expired    = 1'b0;
        case (item.mode)
            cdts_pkg::EV_TICK: begin
                if (run_reg && mode_reg == cdts_pkg::MODE_COUNTDOWN) begin
                    // Borrow down through seconds, minutes, hours
                    if (!at_zero) begin
                        if (secs_reg != '0) begin
                            secs_next = secs_reg - 1'b1;
                        end else if (mins_reg != '0) begin
                            mins_next = mins_reg - 1'b1;
                            secs_next = cdts_pkg::MAX_SM;
                        end else begin
                            hours_next = hours_reg - 1'b1;
                            mins_next  = cdts_pkg::MAX_SM;
                            secs_next  = cdts_pkg::MAX_SM;
                        end
                    end
                    if (hours_next == '0 && mins_next == '0 && secs_next == '0) begin
                        mode_next = cdts_pkg::MODE_IDLE;
                        run_next  = 1'b0;
                        expired   = 1'b1;
                    end
                end else if (run_reg && mode_reg == cdts_pkg::MODE_COUNT_UP) begin
                    // Carry up, hold at the top of the range
                    if (!at_max) begin
                        if (secs_reg == cdts_pkg::MAX_SM) begin
                            secs_next = '0;
                            if (mins_reg == cdts_pkg::MAX_SM) begin
                                mins_next  = '0;
                                hours_next = hours_reg + 1'b1;
                            end else begin
                                mins_next = mins_reg + 1'b1;
                            end
                        end else begin
                            secs_next = secs_reg + 1'b1;
                        end
                    end
                end
            end
            cdts_pkg::EV_MODE: begin
                run_next = 1'b0;
                case (mode_reg)
                    cdts_pkg::MODE_IDLE:      mode_next = cdts_pkg::MODE_COUNTDOWN;
                    cdts_pkg::MODE_COUNTDOWN: mode_next = cdts_pkg::MODE_COUNT_UP;
                    default:                  mode_next = cdts_pkg::MODE_IDLE;
                endcase
            end
            cdts_pkg::EV_START: begin
                run_next = (mode_reg == cdts_pkg::MODE_IDLE) ? 1'b0 : !run_reg;
            end
            cdts_pkg::EV_RESET: begin
                run_next   = 1'b0;
                hours_next = '0;
                mins_next  = '0;
                secs_next  = '0;
            end
            cdts_pkg::EV_ADJUST: begin
                case (item.unit)
                    cdts_pkg::UNIT_SECS: begin
                        secs_next = secs_adj[cdts_pkg::SECS_W-1:0];
                    end
                    cdts_pkg::UNIT_MINS: begin
                        mins_next = mins_adj[cdts_pkg::MINS_W-1:0];
                    end
                    cdts_pkg::UNIT_HOURS: begin
                        hours_next = cdts_pkg::sat_adj(hours_reg, item.direction,
                                         item.big_step, cdts_pkg::MAX_HR);
                    end
                    default: begin
                        hours_next = hours_reg;
                    end
                endcase
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
        // Idle mode never runs
        if (mode_next == cdts_pkg::MODE_IDLE) begin
            run_next = 1'b0;
        end
    end

    // State registers advance once per event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= cdts_pkg::MODE_IDLE;
            run_reg   <= 1'b0;
            hours_reg <= '0;
            mins_reg  <= '0;
            secs_reg  <= '0;
        end else if (upd) begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            hours_reg <= hours_next;
            mins_reg  <= mins_next;
            secs_reg  <= secs_next;
        end
    end

    assign res.expired  = expired;
    assign res.running  = run_next;
    assign res.run_mode = mode_next;
    assign res.seconds  = secs_next;
    assign res.minutes  = mins_next;
    assign res.hours    = hours_next;

endmodule

// ===== rtl/countdown_timer_stopwatch_unit.sv =====
// Countdown timer / stopwatch top level: input register, event engine, result register.
// An accepted beat passes through the input register and then the result register to m_tdata.
// Throughput: one event beat per cycle while m_tready is high; the result register frees as soon as it is taken.
// Back-pressure on m_tready reaches s_tready in the same cycle through the input register.
// Reset (aresetn low, synchronous): idle mode, stopped, count 00:00:00, no beats held.
`timescale 1ns / 1ps

module countdown_timer_stopwatch_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] unit, [2] direction, [3] big_step, [7:4] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode (event kind)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [6:0] hours, [12:7] minutes, [18:13] seconds,
                                   // [20:19] run_mode, [21] running, [22] expired, [23] zero
);

    cdts_pkg::item_t s_item;
    cdts_pkg::item_t item;
    cdts_pkg::res_t  res;
    cdts_pkg::res_t  res_reg;
    logic            item_valid;
    logic            out_ready;
    logic            upd;
    logic            m_valid_reg;
    logic            m_valid_next;

    // Unpack the input beat
    assign s_item.mode      = s_tuser;
    assign s_item.unit      = s_tdata[1:0];
    assign s_item.direction = s_tdata[2];
    assign s_item.big_step  = s_tdata[3];

    // Result slot is free when empty or being taken
    assign out_ready = !m_valid_reg || m_tready;
    assign upd       = item_valid && out_ready;

    cdts_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .pop        (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    cdts_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .item    (item),
        .res     (res)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_ready) begin
            m_valid_next = item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    // Expiry always leaves the block idle, stopped and at zero
    a_expired_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.expired |->
            res_reg.run_mode == cdts_pkg::MODE_IDLE && !res_reg.running
            && res_reg.hours == '0 && res_reg.minutes == '0 && res_reg.seconds == '0)
        else $error("expired result not idle at zero");

    // A running result is never in idle mode
    a_run_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.running |-> res_reg.run_mode != cdts_pkg::MODE_IDLE)
        else $error("running flag set in idle mode");

    // Count fields stay within their ranges
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> res_reg.hours <= cdts_pkg::MAX_HR
            && res_reg.minutes <= cdts_pkg::MAX_SM && res_reg.seconds <= cdts_pkg::MAX_SM)
        else $error("count field out of range");

    // A held input beat is not dropped while the result side stalls
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !out_ready |=> item_valid)
        else $error("input beat lost under back-pressure");

endmodule

// ===== tb/tb.sv =====
// Testbench for the countdown timer / stopwatch: directed and random event beats.
`timescale 1ns / 1ps

module tb;

    // Codes outside the defined event kinds and units
    localparam logic [2:0] EV_SPARE      = 3'd7;
    localparam logic [1:0] UNIT_SPARE    = 2'd3;
    localparam int         RANDOM_EVENTS = 410;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [1:0] unit, [2] direction, [3] big_step, [7:4] zero
    logic [2:0]  s_tuser  = '0;   // [2:0] mode (event kind)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [6:0] hours, [12:7] minutes, [18:13] seconds,
                                  // [20:19] run_mode, [21] running, [22] expired, [23] zero

    // Behavioural copy of the clock state
    logic [cdts_pkg::HOURS_W-1:0] hrs  = '0;
    logic [cdts_pkg::MINS_W-1:0]  mins = '0;
    logic [cdts_pkg::SECS_W-1:0]  secs = '0;
    cdts_pkg::mode_t              op   = cdts_pkg::MODE_IDLE;
    logic                         run  = 1'b0;

    cdts_pkg::res_t display_q[$];
    int   failures    = 0;
    int   events_sent = 0;
    int   rx_hold     = 0;
    bit   tx_quiet    = 1'b0;
    bit   rx_quiet    = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    countdown_timer_stopwatch_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Step a unit by one or ten, clamped to 0 and to top
    function automatic int clamp_step(int v, bit up, bit big, int top);
        int step;
        step = big ? int'(cdts_pkg::BIG_STEP) : int'(cdts_pkg::SMALL_STEP);
        if (up) return (v + step > top) ? top : v + step;
        return (v < step) ? 0 : v - step;
    endfunction

    function automatic bit count_is_zero();
        return hrs == 0 && mins == 0 && secs == 0;
    endfunction

    // Apply one event to the clock state and return the display it leaves
    function automatic cdts_pkg::res_t next_display(logic [2:0] ev, logic [1:0] unit,
                                                    bit up, bit big);
        cdts_pkg::res_t r;
        bit             expired;
        int             adj_v;
        expired = 1'b0;
        case (ev)
            cdts_pkg::EV_TICK: begin
                if (run && op == cdts_pkg::MODE_COUNTDOWN) begin
                    // count down with borrow, expire on zero
                    if (!count_is_zero()) begin
                        if (secs != 0) begin
                            secs = secs - 1'b1;
                        end else if (mins != 0) begin
                            mins = mins - 1'b1;
                            secs = cdts_pkg::MAX_SM;
                        end else begin
                            hrs  = hrs - 1'b1;
                            mins = cdts_pkg::MAX_SM;
                            secs = cdts_pkg::MAX_SM;
                        end
                    end
                    if (count_is_zero()) begin
                        op      = cdts_pkg::MODE_IDLE;
                        run     = 1'b0;
                        expired = 1'b1;
                    end
                end else if (run && op == cdts_pkg::MODE_COUNT_UP) begin
                    // count up with carry, hold at the top
                    if (!(hrs == cdts_pkg::MAX_HR && mins == cdts_pkg::MAX_SM
                          && secs == cdts_pkg::MAX_SM)) begin
                        if (secs == cdts_pkg::MAX_SM) begin
                            secs = '0;
                            if (mins == cdts_pkg::MAX_SM) begin
                                mins = '0;
                                hrs  = hrs + 1'b1;
                            end else begin
                                mins = mins + 1'b1;
                            end
                        end else begin
                            secs = secs + 1'b1;
                        end
                    end
                end
            end
            cdts_pkg::EV_MODE: begin
                run = 1'b0;
                case (op)
                    cdts_pkg::MODE_IDLE:      op = cdts_pkg::MODE_COUNTDOWN;
                    cdts_pkg::MODE_COUNTDOWN: op = cdts_pkg::MODE_COUNT_UP;
                    default:                  op = cdts_pkg::MODE_IDLE;
                endcase
            end
            cdts_pkg::EV_START: run = (op == cdts_pkg::MODE_IDLE) ? 1'b0 : ~run;
            cdts_pkg::EV_RESET: begin
                run  = 1'b0;
                hrs  = '0;
                mins = '0;
                secs = '0;
            end
            cdts_pkg::EV_ADJUST: begin
                case (unit)
                    cdts_pkg::UNIT_SECS: begin
                        adj_v = clamp_step(int'(secs), up, big, int'(cdts_pkg::MAX_SM));
                        secs  = adj_v[cdts_pkg::SECS_W-1:0];
                    end
                    cdts_pkg::UNIT_MINS: begin
                        adj_v = clamp_step(int'(mins), up, big, int'(cdts_pkg::MAX_SM));
                        mins  = adj_v[cdts_pkg::MINS_W-1:0];
                    end
                    cdts_pkg::UNIT_HOURS: begin
                        adj_v = clamp_step(int'(hrs), up, big, int'(cdts_pkg::MAX_HR));
                        hrs   = adj_v[cdts_pkg::HOURS_W-1:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (op == cdts_pkg::MODE_IDLE) run = 1'b0;
        r.hours    = hrs;
        r.minutes  = mins;
        r.seconds  = secs;
        r.run_mode = op;
        r.running  = run;
        r.expired  = expired;
        return r;
    endfunction

    // Drive one event beat, wait for it to be taken, then queue its display
    task automatic send_event(logic [2:0] ev, logic [1:0] unit, bit up, bit big);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= ev;
        s_tdata  <= {4'b0000, big, up, unit};
        do @(posedge aclk); while (!s_tready);
        display_q.push_back(next_display(ev, unit, up, big));
        events_sent++;
    endtask

    // Event whose adjust fields are ignored: fill them at random
    task automatic send_plain(logic [2:0] ev);
        send_event(ev, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic enter_mode(cdts_pkg::mode_t target);
        while (op != target) send_plain(cdts_pkg::EV_MODE);
    endtask

    // Stall the result side at random
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap(rx_quiet);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Compare each result beat with the oldest queued display
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (display_q.size() == 0) begin
                $error("result beat with no event outstanding");
                failures++;
            end else begin
                check_field("hours",    int'(display_q[0].hours),    int'(m_tdata[6:0]));
                check_field("minutes",  int'(display_q[0].minutes),  int'(m_tdata[12:7]));
                check_field("seconds",  int'(display_q[0].seconds),  int'(m_tdata[18:13]));
                check_field("run_mode", int'(display_q[0].run_mode), int'(m_tdata[20:19]));
                check_field("running",  int'(display_q[0].running),  int'(m_tdata[21]));
                check_field("expired",  int'(display_q[0].expired),  int'(m_tdata[22]));
                void'(display_q.pop_front());
            end
        end
    end

    // Idle mode holds the run flag; unknown kinds change nothing
    task automatic test_idle_events();
        send_event(cdts_pkg::EV_TICK, cdts_pkg::UNIT_SECS, 1'b0, 1'b0);
        send_event(cdts_pkg::EV_START, cdts_pkg::UNIT_SECS, 1'b0, 1'b0);
        send_event(EV_SPARE, UNIT_SPARE, 1'b1, 1'b1);
    endtask

    // Saturation at zero, both step sizes, unknown unit
    task automatic test_adjust_limits();
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b0, 1'b0);
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_HOURS, 1'b1, 1'b1);
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_HOURS, 1'b0, 1'b0);
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_HOURS, 1'b0, 1'b1);
        send_event(cdts_pkg::EV_ADJUST, UNIT_SPARE, 1'b1, 1'b1);
    endtask

    // Expiry on a zero count, borrow through hours, expiry on reaching zero
    task automatic test_countdown();
        send_plain(cdts_pkg::EV_RESET);
        send_plain(cdts_pkg::EV_MODE);
        send_plain(cdts_pkg::EV_START);
        send_plain(cdts_pkg::EV_TICK);
        send_plain(cdts_pkg::EV_MODE);
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_HOURS, 1'b1, 1'b0);
        send_plain(cdts_pkg::EV_START);
        send_plain(cdts_pkg::EV_TICK);
        send_plain(cdts_pkg::EV_RESET);
        send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b1, 1'b0);
        send_plain(cdts_pkg::EV_START);
        send_plain(cdts_pkg::EV_TICK);
    endtask

    // Running and stopped ticks, reset keeping the mode, mode wrap to idle
    task automatic test_count_up();
        enter_mode(cdts_pkg::MODE_COUNT_UP);
        send_plain(cdts_pkg::EV_START);
        send_plain(cdts_pkg::EV_TICK);
        send_plain(cdts_pkg::EV_START);
        send_plain(cdts_pkg::EV_TICK);
        send_plain(cdts_pkg::EV_RESET);
        send_plain(cdts_pkg::EV_MODE);
    endtask

    // Mostly well-formed runs with random content, some noise
    task automatic test_random();
        int  stop_at;
        int  kind;
        int  n;
        bit  drained;
        stop_at = events_sent + RANDOM_EVENTS;
        drained = 1'b0;
        while (events_sent < stop_at) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // fill to 59:59 and run the count-up into an hour carry or the top
                send_plain(cdts_pkg::EV_RESET);
                repeat (6) send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b1, 1'b1);
                repeat (6) send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_MINS, 1'b1, 1'b1);
                if ($urandom_range(0, 1))
                    repeat (10) send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_HOURS,
                                           1'b1, 1'b1);
                else
                    repeat ($urandom_range(0, 3)) send_event(cdts_pkg::EV_ADJUST,
                                                             cdts_pkg::UNIT_HOURS, 1'b1, 1'b0);
                enter_mode(cdts_pkg::MODE_COUNT_UP);
                send_plain(cdts_pkg::EV_START);
                repeat ($urandom_range(1, 4)) send_plain(cdts_pkg::EV_TICK);
            end else if (kind < 45) begin
                // preset a short count and run it down, pausing now and then
                send_plain(cdts_pkg::EV_RESET);
                repeat ($urandom_range(0, 4))
                    send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b1, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b1, 1'b1);
                if ($urandom_range(0, 5) == 0)
                    send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_MINS, 1'b1, 1'b0);
                enter_mode(cdts_pkg::MODE_COUNTDOWN);
                send_plain(cdts_pkg::EV_START);
                n = 0;
                while (op == cdts_pkg::MODE_COUNTDOWN && n < 75) begin
                    send_plain(($urandom_range(0, 19) == 0) ? cdts_pkg::EV_START
                                                            : cdts_pkg::EV_TICK);
                    n++;
                end
            end else if (kind < 75) begin
                // run the count-up, often from just below a minute carry
                enter_mode(cdts_pkg::MODE_COUNT_UP);
                if ($urandom_range(0, 1)) send_plain(cdts_pkg::EV_RESET);
                if ($urandom_range(0, 1))
                    repeat (5) send_event(cdts_pkg::EV_ADJUST, cdts_pkg::UNIT_SECS, 1'b1, 1'b1);
                send_plain(cdts_pkg::EV_START);
                repeat ($urandom_range(5, 40))
                    send_plain(($urandom_range(0, 14) == 0) ? cdts_pkg::EV_START
                                                            : cdts_pkg::EV_TICK);
            end else if (kind < 88) begin
                repeat ($urandom_range(3, 10))
                    send_event(cdts_pkg::EV_ADJUST, 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            // halfway: hold off until every queued display has come back
            if (!drained && events_sent >= stop_at - RANDOM_EVENTS / 2) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (display_q.size() != 0) @(posedge aclk);
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_events();
        test_adjust_limits();
        test_countdown();
        test_count_up();
        test_random();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (display_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== countdown_timer_stopwatch_unit.f =====
rtl/cdts_pkg.sv
rtl/cdts_in_stage.sv
rtl/cdts_engine.sv
rtl/countdown_timer_stopwatch_unit.sv
tb/tb.sv
